[rtl/vbd_pkg.sv]
package vbd_pkg;

    // Bytes held for the longest block code (a, b and eight colours).
    localparam int CODE_BYTES = 10;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_ACROSS = 2'd0;
    localparam logic [1:0] REG_DOWN   = 2'd1;
    localparam logic [1:0] REG_PITCH  = 2'd2;

    // Thresholds on the second byte of a code.
    localparam logic [7:0] B_TWO_END  = 8'h80;
    localparam logic [7:0] B_SKIP_LO  = 8'h84;
    localparam logic [7:0] B_SKIP_END = 8'h88;
    localparam logic [7:0] B_EIGHT_LO = 8'h90;

    // Code lengths in bytes.
    localparam logic [3:0] LEN_TWO   = 4'd4;
    localparam logic [3:0] LEN_EIGHT = 4'd10;
    localparam logic [3:0] LEN_SHORT = 4'd2;

    // Code classes.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_FILL  = 2'd0;
    localparam kind_t KIND_TWO   = 2'd1;
    localparam kind_t KIND_EIGHT = 2'd2;
    localparam kind_t KIND_SKIP  = 2'd3;

    // One complete block code as handed from the byte collector to the executor.
    typedef struct packed {
        logic            fs;
        kind_t           kind;
        logic [7:0]      a;
        logic [7:0]      b;
        logic [7:0][7:0] colours;
    } code_t;

    // Frame geometry registers.
    typedef struct packed {
        logic [8:0]  across;
        logic [8:0]  down;
        logic [12:0] pitch;
    } cfg_t;

    // One result leaving the executor.
    typedef struct packed {
        logic [31:0] pixels;
        logic        we;
        logic        last;
        logic        done;
    } result_t;

endpackage

[rtl/vbd_front.sv]
module vbd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    code_byte,
    input  logic          frame_start,
    output logic          push,
    output vbd_pkg::code_t push_code
);

    logic [7:0] bytes_reg [vbd_pkg::CODE_BYTES];
    logic [7:0] bytes_next [vbd_pkg::CODE_BYTES];
    logic [3:0] held_reg;
    logic [3:0] held_next;
    logic       fs_first_reg;
    logic       fs_first_next;
    logic [3:0] idx;
    logic [3:0] cnt;
    logic [3:0] need;
    logic [7:0] b_cur;

    function automatic logic [3:0] code_length(input logic [7:0] b);
        if (b < vbd_pkg::B_TWO_END)
            return vbd_pkg::LEN_TWO;
        else if (b >= vbd_pkg::B_EIGHT_LO)
            return vbd_pkg::LEN_EIGHT;
        else
            return vbd_pkg::LEN_SHORT;
    endfunction

    function automatic vbd_pkg::kind_t classify(input logic [7:0] b);
        if (b < vbd_pkg::B_TWO_END)
            return vbd_pkg::KIND_TWO;
        else if (b >= vbd_pkg::B_EIGHT_LO)
            return vbd_pkg::KIND_EIGHT;
        else if (b >= vbd_pkg::B_SKIP_LO && b < vbd_pkg::B_SKIP_END)
            return vbd_pkg::KIND_SKIP;
        else
            return vbd_pkg::KIND_FILL;
    endfunction

    always_comb
    begin
        // A frame start throws away any partial code and begins a new one.
        idx = frame_start ? 4'd0 : held_reg;
        bytes_next = bytes_reg;
        if (accept)
        begin
            bytes_next[idx] = code_byte;
        end
        cnt   = idx + 4'd1;
        b_cur = bytes_next[1];
        need  = code_length(b_cur);
        push  = accept && (cnt >= 4'd2) && (cnt == need);

        held_next = held_reg;
        if (accept)
        begin
            held_next = push ? 4'd0 : cnt;
        end
        fs_first_next = (accept && idx == 4'd0) ? frame_start : fs_first_reg;

        push_code.fs   = (idx == 4'd0) ? frame_start : fs_first_reg;
        push_code.kind = classify(b_cur);
        push_code.a    = bytes_next[0];
        push_code.b    = b_cur;
        for (int i = 0; i < 8; i++)
        begin
            push_code.colours[i] = bytes_next[i + 2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= 4'd0;
            fs_first_reg <= 1'b0;
        end
        else
        begin
            held_reg     <= held_next;
            fs_first_reg <= fs_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

[rtl/vbd_queue.sv]
module vbd_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vbd_pkg::code_t push_code,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output vbd_pkg::code_t pop_code
);

    vbd_pkg::code_t slots_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_code = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_code;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("code queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("code queue read while empty");

endmodule

[rtl/vbd_back.sv]
module vbd_back
#(
    parameter int ADDR_BITS  = 20,
    parameter int MAX_BLOCKS = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  vbd_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  vbd_pkg::code_t  q_code,
    output logic            q_pop,
    output logic            out_valid,
    output logic [ADDR_BITS-1:0] out_addr,
    output vbd_pkg::result_t out_res,
    input  logic            out_ready
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROWS = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;

    logic [1:0]           state_reg, state_next;
    vbd_pkg::code_t       code_reg, code_next;
    logic [1:0]           row_cnt_reg, row_cnt_next;
    logic [ADDR_BITS-1:0] row_addr_reg, row_addr_next;
    logic [9:0]           skip_cnt_reg, skip_cnt_next;
    logic [CW-1:0]        column_reg, column_next;
    logic [CW-1:0]        brow_reg, brow_next;
    logic [ADDR_BITS-1:0] row_base_reg, row_base_next;
    logic                 finished_reg, finished_next;
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;
    vbd_pkg::result_t     out_res_reg, out_res_next;

    logic [CW-1:0]        across_eff, down_eff;
    logic [CW-1:0]        col_inc, brow_inc;
    logic                 wrap;
    logic [CW-1:0]        adv_col, adv_row;
    logic [ADDR_BITS-1:0] adv_base;
    logic                 adv_fin;
    logic                 slot_free;
    logic [ADDR_BITS-1:0] base_eff;
    logic [CW-1:0]        col_eff;
    logic [9:0]           skip_n;

    function automatic logic [31:0] row_pixels(input vbd_pkg::code_t c, input logic [1:0] r);
        logic [15:0] flags;
        logic        bit_sel;
        logic [7:0]  pix;
        logic [31:0] res;
        flags = ~{c.b, c.a};
        res   = 32'd0;
        for (int x = 0; x < 4; x++)
        begin
            bit_sel = flags[{r, 2'(x)}];
            case (c.kind)
                vbd_pkg::KIND_TWO:   pix = c.colours[{2'b00, bit_sel}];
                vbd_pkg::KIND_EIGHT: pix = c.colours[{r[1], 1'(x >> 1), bit_sel}];
                default:             pix = c.a;
            endcase
            res[8*x +: 8] = pix;
        end
        return res;
    endfunction

    // Geometry registers are clamped to one block and to the largest frame.
    always_comb
    begin
        if (cfg.across == 9'd0)
            across_eff = CW'(1);
        else if (32'(cfg.across) > 32'(MAX_BLOCKS))
            across_eff = CW'(MAX_BLOCKS);
        else
            across_eff = CW'(cfg.across);
        if (cfg.down == 9'd0)
            down_eff = CW'(1);
        else if (32'(cfg.down) > 32'(MAX_BLOCKS))
            down_eff = CW'(MAX_BLOCKS);
        else
            down_eff = CW'(cfg.down);
    end

    // Position after one block step.
    always_comb
    begin
        col_inc  = column_reg + CW'(1);
        brow_inc = brow_reg + CW'(1);
        wrap     = (col_inc >= across_eff);
        adv_col  = wrap ? CW'(0) : col_inc;
        adv_row  = wrap ? brow_inc : brow_reg;
        adv_base = wrap ? (row_base_reg + ADDR_BITS'({cfg.pitch, 2'b00})) : row_base_reg;
        adv_fin  = wrap && (brow_inc >= down_eff);
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign skip_n    = {q_code.b[1:0], q_code.a};   // ((b - 0x84) << 8) + a
    assign base_eff  = q_code.fs ? '0 : row_base_reg;
    assign col_eff   = q_code.fs ? '0 : column_reg;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        row_cnt_next   = row_cnt_reg;
        row_addr_next  = row_addr_reg;
        skip_cnt_next  = skip_cnt_reg;
        column_next    = column_reg;
        brow_next      = brow_reg;
        row_base_next  = row_base_reg;
        finished_next  = finished_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_addr_next  = out_addr_reg;
        out_res_next   = out_res_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    code_next = q_code;
                    if (q_code.fs)
                    begin
                        column_next   = '0;
                        brow_next     = '0;
                        row_base_next = '0;
                        finished_next = 1'b0;
                    end
                    // Codes arriving after the end of a frame are dropped.
                    if (q_code.fs || !finished_reg)
                    begin
                        if (q_code.kind == vbd_pkg::KIND_SKIP)
                        begin
                            skip_cnt_next = skip_n;
                            if (skip_n == 10'd0)
                            begin
                                finished_next = 1'b1;
                            end
                            state_next = ST_SKIP;
                        end
                        else
                        begin
                            row_cnt_next  = 2'd0;
                            row_addr_next = base_eff + ADDR_BITS'({col_eff, 2'b00});
                            state_next    = ST_ROWS;
                        end
                    end
                end
            end
            ST_ROWS:
            begin
                if (slot_free)
                begin
                    out_valid_next      = 1'b1;
                    out_addr_next       = row_addr_reg;
                    out_res_next.pixels = row_pixels(code_reg, row_cnt_reg);
                    out_res_next.we     = 1'b1;
                    out_res_next.last   = (row_cnt_reg == 2'd3);
                    out_res_next.done   = (row_cnt_reg == 2'd3) && adv_fin;
                    row_addr_next       = row_addr_reg + ADDR_BITS'(cfg.pitch);
                    row_cnt_next        = row_cnt_reg + 2'd1;
                    if (row_cnt_reg == 2'd3)
                    begin
                        column_next   = adv_col;
                        brow_next     = adv_row;
                        row_base_next = adv_base;
                        finished_next = adv_fin;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_SKIP:
            begin
                if (skip_cnt_reg == 10'd0 || finished_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next      = 1'b1;
                        out_addr_next       = '0;
                        out_res_next.pixels = 32'd0;
                        out_res_next.we     = 1'b0;
                        out_res_next.last   = 1'b1;
                        out_res_next.done   = finished_reg;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    column_next   = adv_col;
                    brow_next     = adv_row;
                    row_base_next = adv_base;
                    finished_next = adv_fin;
                    skip_cnt_next = skip_cnt_reg - 10'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            column_reg    <= '0;
            brow_reg      <= '0;
            row_base_reg  <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            column_reg    <= column_next;
            brow_reg      <= brow_next;
            row_base_reg  <= row_base_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        row_cnt_reg  <= row_cnt_next;
        row_addr_reg <= row_addr_next;
        skip_cnt_reg <= skip_cnt_next;
        out_addr_reg <= out_addr_next;
        out_res_reg  <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_res   = out_res_reg;

    a_skip_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_res_reg.we) |-> out_res_reg.last)
        else $error("skip notice without end-of-code mark");

    a_rows_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS && row_cnt_reg == 2'd3 && slot_free) |=> state_reg == ST_IDLE)
        else $error("block decode did not finish after its fourth row");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg < CW'(MAX_BLOCKS))
        else $error("block column outside the frame");

endmodule

[rtl/video1_8bit_block_decoder.sv]
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: code_byte; tuser: frame_start
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: write_addr, row_pixels;
//                                                tuser: write_enable, frame_done;
//                                                tlast: last_of_code
// cfg       in   cfg_write (no back-pressure)    cfg_index, cfg_data
//
// Each compressed byte is one transfer; complete codes wait in a two-entry queue. The
// executor takes a code from the queue, then writes the block's four rows in turn, or steps
// over each skipped block and then sends the notice; the row loop sets the pace for fill codes.
// Reset is asynchronous and active low; afterwards bytes are ignored until a frame start.
// Input stalls only when the code queue is full; a held result stalls the executor behind it.
module video1_8bit_block_decoder
#(
    parameter int ADDR_BITS  = 20,
    parameter int MAX_BLOCKS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] code_byte
    input  logic        s_axis_tuser,   // [0] frame_start

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [19:0] write_addr, [51:20] row_pixels, rest zero
    output logic [1:0]  m_axis_tuser,   // [0] write_enable, [1] frame_done
    output logic        m_axis_tlast,   // last_of_code

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    // The address port is twenty bits; narrower address spaces are zero-extended.
    localparam int OW = (ADDR_BITS < 20) ? ADDR_BITS : 20;

    logic [8:0]  across_reg;
    logic [8:0]  down_reg;
    logic [12:0] pitch_reg;

    vbd_pkg::cfg_t    cfg;
    logic             in_accept;
    logic             push;
    vbd_pkg::code_t   push_code;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    vbd_pkg::code_t   q_code;
    logic             out_valid;
    logic [ADDR_BITS-1:0] out_addr;
    vbd_pkg::result_t out_res;

    // Geometry registers; writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            across_reg <= 9'd39;
            down_reg   <= 9'd30;
            pitch_reg  <= 13'd156;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vbd_pkg::REG_ACROSS: across_reg <= cfg_data[8:0];
                vbd_pkg::REG_DOWN:   down_reg   <= cfg_data[8:0];
                vbd_pkg::REG_PITCH:  pitch_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg.across = across_reg;
    assign cfg.down   = down_reg;
    assign cfg.pitch  = pitch_reg;

    // A byte transfer needs room in the queue for the code it might complete.
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    vbd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .code_byte   (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .push_code   (push_code)
    );

    vbd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_code (push_code),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_code  (q_code)
    );

    vbd_back
    #(
        .ADDR_BITS  (ADDR_BITS),
        .MAX_BLOCKS (MAX_BLOCKS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_code    (q_code),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_addr  (out_addr),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {4'b0000, out_res.pixels, 20'(out_addr[OW-1:0])};
    assign m_axis_tuser  = {out_res.done, out_res.we};
    assign m_axis_tlast  = out_res.last;

endmodule

[tb/vbd_frame_checker.sv]
`timescale 1ns / 100ps

// Watches the byte, result and register ports of the block decoder and keeps its own
// copy of the decoder state, so that every accepted result can be compared against the
// row write (or skip notice) that the accepted bytes call for.
module vbd_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,

    input  logic        run_over,
    output int          fail_count,
    output int          pending_rows,
    output int          live_bytes,
    output logic        frame_idle
);

    localparam int MAX_BLOCKS = 256;

    typedef struct packed {
        logic [19:0] addr;
        logic [31:0] pixels;
        logic        we;
        logic        last;
        logic        done;
    } row_write_t;

    row_write_t expected_writes[$];

    logic [8:0]  geo_across;
    logic [8:0]  geo_down;
    logic [12:0] geo_pitch;
    logic [7:0]  held [0:vbd_pkg::CODE_BYTES-1];
    int          held_count;
    int          blk_col;
    int          blk_row;
    logic [19:0] row_origin;
    logic        awaiting_start;
    int          mismatches;
    int          accepted_live;
    logic        leftovers_checked;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int fit_blocks(input logic [8:0] v);
        if (v == 9'd0)
            return 1;
        if (int'(v) > MAX_BLOCKS)
            return MAX_BLOCKS;
        return int'(v);
    endfunction

    function automatic vbd_pkg::kind_t code_kind(input logic [7:0] b);
        if (b < vbd_pkg::B_TWO_END)
            return vbd_pkg::KIND_TWO;
        if (b >= vbd_pkg::B_EIGHT_LO)
            return vbd_pkg::KIND_EIGHT;
        if (b >= vbd_pkg::B_SKIP_LO && b < vbd_pkg::B_SKIP_END)
            return vbd_pkg::KIND_SKIP;
        return vbd_pkg::KIND_FILL;
    endfunction

    task automatic next_block();
        if (!awaiting_start)
        begin
            blk_col++;
            if (blk_col >= fit_blocks(geo_across))
            begin
                blk_col = 0;
                blk_row++;
                row_origin = row_origin + 20'({geo_pitch, 2'b00});
                if (blk_row >= fit_blocks(geo_down))
                    awaiting_start = 1'b1;
            end
        end
    endtask

    // Four row writes for one decoded block; the last one carries the end-of-code
    // mark and, after the position has moved on, the end-of-frame flag.
    task automatic decode_rows(input vbd_pkg::kind_t kind, input logic [7:0] a,
                               input logic [7:0] b);
        logic [15:0] flags;
        row_write_t  rw;
        int          r;
        int          x;
        int          sel;
        logic [7:0]  colour;
        flags = ~{b, a};
        for (r = 0; r < 4; r++)
        begin
            rw = '0;
            for (x = 0; x < 4; x++)
            begin
                sel = int'(flags[4 * r + x]);
                if (kind == vbd_pkg::KIND_TWO)
                    colour = held[2 + sel];
                else if (kind == vbd_pkg::KIND_EIGHT)
                    colour = held[2 + ((r & 2) << 1) + (x & 2) + sel];
                else
                    colour = a;
                rw.pixels[8 * x +: 8] = colour;
            end
            rw.addr = 20'(int'(row_origin) + 4 * blk_col + r * int'(geo_pitch));
            rw.we   = 1'b1;
            if (r == 3)
            begin
                next_block();
                rw.last = 1'b1;
                rw.done = awaiting_start;
            end
            expected_writes.push_back(rw);
        end
    endtask

    task automatic take_byte(input logic [7:0] value, input logic fs);
        logic [7:0]     a;
        logic [7:0]     b;
        vbd_pkg::kind_t kind;
        int             need;
        int             n;
        int             i;
        row_write_t     rw;
        if (fs)
        begin
            held_count     = 0;
            blk_col        = 0;
            blk_row        = 0;
            row_origin     = '0;
            awaiting_start = 1'b0;
        end
        if (!awaiting_start)
        begin
            accepted_live++;
            if (held_count >= vbd_pkg::CODE_BYTES)
                held_count = 0;
            held[held_count] = value;
            held_count++;
            if (held_count >= 2)
            begin
                a    = held[0];
                b    = held[1];
                kind = code_kind(b);
                if (kind == vbd_pkg::KIND_TWO)
                    need = int'(vbd_pkg::LEN_TWO);
                else if (kind == vbd_pkg::KIND_EIGHT)
                    need = int'(vbd_pkg::LEN_EIGHT);
                else
                    need = int'(vbd_pkg::LEN_SHORT);
                if (held_count >= need)
                begin
                    held_count = 0;
                    if (kind == vbd_pkg::KIND_SKIP)
                    begin
                        n = int'(b - vbd_pkg::B_SKIP_LO) * 256 + int'(a);
                        if (n == 0)
                            awaiting_start = 1'b1;
                        for (i = 0; i < n && !awaiting_start; i++)
                            next_block();
                        rw      = '0;
                        rw.last = 1'b1;
                        rw.done = awaiting_start;
                        expected_writes.push_back(rw);
                    end
                    else
                        decode_rows(kind, a, b);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        row_write_t want;
        if (!rst_n)
        begin
            geo_across        = 9'd39;
            geo_down          = 9'd30;
            geo_pitch         = 13'd156;
            held_count        = 0;
            blk_col           = 0;
            blk_row           = 0;
            row_origin        = '0;
            awaiting_start    = 1'b1;
            accepted_live     = 0;
            leftovers_checked = 1'b0;
            for (int k = 0; k < vbd_pkg::CODE_BYTES; k++)
                held[k] = 8'h00;
            expected_writes.delete();
            fail_count   <= mismatches;
            pending_rows <= 0;
            live_bytes   <= 0;
            frame_idle   <= 1'b1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_writes.size() == 0)
                    report_mismatch("result with nothing expected",
                                    32'(m_axis_tdata[19:0]), 32'd0);
                else
                begin
                    want = expected_writes.pop_front();
                    if (m_axis_tdata[19:0] !== want.addr)
                        report_mismatch("write_addr", 32'(m_axis_tdata[19:0]),
                                        32'(want.addr));
                    if (m_axis_tdata[51:20] !== want.pixels)
                        report_mismatch("row_pixels", m_axis_tdata[51:20], want.pixels);
                    if (m_axis_tuser[0] !== want.we)
                        report_mismatch("write_enable", 32'(m_axis_tuser[0]), 32'(want.we));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last_of_code", 32'(m_axis_tlast), 32'(want.last));
                    if (m_axis_tuser[1] !== want.done)
                        report_mismatch("frame_done", 32'(m_axis_tuser[1]), 32'(want.done));
                end
            end

            if (cfg_write)
            begin
                if (cfg_index == vbd_pkg::REG_ACROSS)
                    geo_across = cfg_data[8:0];
                else if (cfg_index == vbd_pkg::REG_DOWN)
                    geo_down = cfg_data[8:0];
                else if (cfg_index == vbd_pkg::REG_PITCH)
                    geo_pitch = cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tuser);

            if (run_over && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_writes.size() != 0)
                    report_mismatch("results never delivered",
                                    32'(expected_writes.size()), 32'd0);
            end

            fail_count   <= mismatches;
            pending_rows <= expected_writes.size();
            live_bytes   <= accepted_live;
            frame_idle   <= awaiting_start;
        end
    end

    initial mismatches = 0;

endmodule

[tb/tb_video1_8bit_block_decoder.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the 8-bit block decoder. The checker instance beside the
// decoder follows every transfer on the byte, result and register ports and counts
// failures; this module only supplies bytes, register writes and back-pressure.
module tb_video1_8bit_block_decoder;

    // Index on the configuration port that selects no register.
    localparam logic [1:0] REG_SPARE  = 2'd3;

    // Cycles allowed after the last expected result before the registers are touched.
    // A byte that only completes part of a code yields nothing, so this covers the
    // collector and the code queue settling.
    localparam int SETTLE_CYCLES   = 16;
    // Length of the deliberate result hold-off, long enough to fill the code queue.
    localparam int HOLD_OFF_CYCLES = 300;
    // Upper bound on the final drain; a long skip advances one block per cycle.
    localparam int DRAIN_LIMIT     = 200000;

    logic        clk;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    logic        run_over;
    int          fail_count;
    int          pending_rows;
    int          live_bytes;
    logic        frame_idle;

    // Shared between the stimulus and the result sink. The stimulus asks for the long
    // hold-off and the sink marks it served; calm switches all idling off near the end.
    bit          calm;
    bit          hold_wanted;
    bit          hold_served;

    video1_8bit_block_decoder u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vbd_frame_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .run_over      (run_over),
        .fail_count    (fail_count),
        .pending_rows  (pending_rows),
        .live_bytes    (live_bytes),
        .frame_idle    (frame_idle)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(5_000_000);
        $display("tb_video1_8bit_block_decoder: FAIL");
        $finish;
    end

    // Offers one byte and returns at the edge where the transfer takes place. Outside the
    // calm stretch the byte is sometimes preceded by a short burst with tvalid low.
    task automatic push_byte(input logic [7:0] value, input logic fs);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sends one well-formed block code of the given class with random content. Skips
    // mostly stay within one byte of count so that they do not dominate the run time.
    task automatic send_code(input vbd_pkg::kind_t kind, input logic fs);
        logic [7:0] a;
        logic [7:0] b;
        int         len;
        int         k;
        a = 8'($urandom);
        if (kind == vbd_pkg::KIND_TWO)
        begin
            b   = 8'($urandom_range(0, int'(vbd_pkg::B_TWO_END) - 1));
            len = int'(vbd_pkg::LEN_TWO);
        end
        else if (kind == vbd_pkg::KIND_EIGHT)
        begin
            b   = 8'($urandom_range(int'(vbd_pkg::B_EIGHT_LO), 255));
            len = int'(vbd_pkg::LEN_EIGHT);
        end
        else if (kind == vbd_pkg::KIND_SKIP)
        begin
            if ($urandom_range(0, 7) == 0)
                b = 8'($urandom_range(int'(vbd_pkg::B_SKIP_LO),
                                      int'(vbd_pkg::B_SKIP_END) - 1));
            else
                b = vbd_pkg::B_SKIP_LO;
            len = int'(vbd_pkg::LEN_SHORT);
        end
        else
        begin
            // A fill code lives either just below the skip range or between it and
            // the eight-colour range.
            if ($urandom_range(0, 1) == 0)
                b = 8'($urandom_range(int'(vbd_pkg::B_TWO_END),
                                      int'(vbd_pkg::B_SKIP_LO) - 1));
            else
                b = 8'($urandom_range(int'(vbd_pkg::B_SKIP_END),
                                      int'(vbd_pkg::B_EIGHT_LO) - 1));
            len = int'(vbd_pkg::LEN_SHORT);
        end
        push_byte(a, fs);
        push_byte(b, 1'b0);
        for (k = 2; k < len; k++)
            push_byte(8'($urandom), 1'b0);
    endtask

    // Lets the decoder run dry: tvalid drops, every expected result has to arrive, and then
    // the SETTLE_CYCLES wait passes so that the collector and the code queue have settled.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rows != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three geometry registers on consecutive edges, then the spare index,
    // which the decoder has to ignore. cfg_write stays high through the whole burst.
    task automatic write_geometry(input logic [12:0] across, input logic [12:0] down,
                                  input logic [12:0] pitch);
        cfg_write <= 1'b1;
        cfg_index <= vbd_pkg::REG_ACROSS;
        cfg_data  <= across;
        @(posedge clk);
        cfg_index <= vbd_pkg::REG_DOWN;
        cfg_data  <= down;
        @(posedge clk);
        cfg_index <= vbd_pkg::REG_PITCH;
        cfg_data  <= pitch;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 13'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random traffic until the given number of bytes has been taken by a live frame.
    // A new frame is opened whenever the previous one has finished, and now and then
    // in the middle of one. About one pick in ten is a lone noise byte, which throws
    // the code alignment off until the next frame start.
    task automatic run_phase(input int budget, input bit fresh);
        int   start;
        int   pick;
        logic fs;
        start = live_bytes;
        fs    = fresh;
        while (live_bytes - start < budget)
        begin
            fs   = fs || frame_idle || ($urandom_range(0, 39) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_code(vbd_pkg::KIND_FILL, fs);
            else if (pick < 60)
                send_code(vbd_pkg::KIND_TWO, fs);
            else if (pick < 80)
                send_code(vbd_pkg::KIND_EIGHT, fs);
            else if (pick < 90)
                send_code(vbd_pkg::KIND_SKIP, fs);
            else
                push_byte(8'($urandom), fs || ($urandom_range(0, 7) == 0));
            fs = 1'b0;
        end
    endtask

    // Result sink. Outside the calm stretch tready drops for random bursts between runs of
    // ready cycles, and once it holds off for a long stretch on request so that the decoder
    // backs up and stalls its byte input.
    initial
    begin : result_sink
        int run;
        m_axis_tready <= 1'b0;
        hold_served = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_wanted && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                run = $urandom_range(1, 3);
                repeat (run) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            run = calm ? 1 : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int waited;
        calm        = 1'b0;
        hold_wanted = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= vbd_pkg::REG_ACROSS;
        cfg_data      <= 13'd0;
        run_over      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a three by two block frame with a pitch of eight bytes.
        write_geometry(13'd3, 13'd2, 13'd8);

        // After reset the decoder waits for a frame start, so this byte is dropped.
        push_byte(8'h12, 1'b0);
        // Fill with the top colour value, opening the frame.
        push_byte(8'hFF, 1'b1);
        push_byte(vbd_pkg::B_TWO_END, 1'b0);
        // Two-colour code whose flag word is all zeros, so every pixel takes the
        // second colour once the flags are inverted.
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Eight-colour code with the largest second byte and a distinct colour in
        // every slot, which ends the first block row.
        push_byte(8'hA5, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h33, 1'b0);
        push_byte(8'h44, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'h66, 1'b0);
        push_byte(8'h77, 1'b0);
        push_byte(8'h88, 1'b0);
        // Skip of a single block.
        push_byte(8'h01, 1'b0);
        push_byte(vbd_pkg::B_SKIP_LO, 1'b0);
        // Largest skip count, which runs past the end of the frame and stops there.
        push_byte(8'hFF, 1'b0);
        push_byte(vbd_pkg::B_SKIP_END - 8'd1, 1'b0);
        // The frame has finished, so this byte is dropped.
        push_byte(8'h55, 1'b0);
        // A frame start part-way through a code throws the held byte away; the new
        // code is a skip with a zero count, which ends the frame at once.
        push_byte(8'h33, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(vbd_pkg::B_SKIP_LO, 1'b0);

        // Geometry changed mid-frame: four blocks into a six-wide row, the row is cut
        // down to three, so the next block is drawn at column four and then wraps, and
        // the one after it starts the second row.
        settle();
        write_geometry(13'd6, 13'd2, 13'd8);
        send_code(vbd_pkg::KIND_FILL, 1'b1);
        repeat (3) send_code(vbd_pkg::KIND_FILL, 1'b0);
        settle();
        write_geometry(13'd3, 13'd2, 13'd8);
        send_code(vbd_pkg::KIND_FILL, 1'b0);
        send_code(vbd_pkg::KIND_TWO, 1'b0);

        // Random part. The first phase carries the long result hold-off.
        settle();
        write_geometry(13'd4, 13'd3, 13'd16);
        hold_wanted = 1'b1;
        run_phase(50, 1'b1);

        // Smallest frame: every block code finishes it.
        settle();
        write_geometry(13'd1, 13'd1, 13'd4);
        run_phase(30, 1'b1);

        // Largest legal geometry; the row origin wraps within the address space.
        settle();
        write_geometry(13'd256, 13'd256, 13'd4096);
        run_phase(50, 1'b1);

        // Out-of-range values: zero width clamps to one block, and the row count and
        // the pitch sit at the top of their register widths.
        settle();
        write_geometry(13'd0, 13'd511, 13'd8191);
        run_phase(30, 1'b1);

        // The other way round, with a pitch of zero so that all rows overlap.
        settle();
        write_geometry(13'd511, 13'd0, 13'd0);
        run_phase(30, 1'b1);

        // Random geometry, with stray bits above the nine-bit block counts.
        settle();
        write_geometry({4'($urandom), 9'($urandom_range(1, 40))},
                       {4'($urandom), 9'($urandom_range(1, 20))},
                       13'($urandom_range(4, 4096)));
        run_phase(50, 1'b1);

        // Final stretch at the reset geometry with no idling on either side.
        settle();
        calm = 1'b1;
        write_geometry(13'd39, 13'd30, 13'd156);
        run_phase(60, 1'b1);

        // Drain: wait for every expected result, then a little longer in case the
        // decoder produces something that nobody asked for.
        s_axis_tvalid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_rows != 0 && waited < DRAIN_LIMIT);
        repeat (32) @(posedge clk);
        run_over <= 1'b1;
        repeat (2) @(posedge clk);

        if (fail_count == 0)
            $display("tb_video1_8bit_block_decoder: PASS");
        else
            $display("tb_video1_8bit_block_decoder: FAIL");
        $finish;
    end

endmodule
